>>> src/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared constants and types for the shortest path block.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int MAX_VERTICES  = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int VERT_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_BITS     = 2 * VERT_BITS;
    localparam int DIST_BITS     = 21;
    localparam int OUT_DIST_BITS = 20;
    localparam int CFG_BITS      = 5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    typedef logic [VERT_BITS-1:0]   t_vert;
    typedef logic [ADDR_BITS-1:0]   t_waddr;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [DIST_BITS-1:0]   t_dist;

    typedef struct packed {
        logic    we;
        t_waddr  addr;
        t_weight data;
    } t_wr;

endpackage

>>> src/dsp_weight_store.sv
// ----------------------------------------------------------------------------
// dsp_weight_store
// Adjacency matrix RAM, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero (no edge).
// ----------------------------------------------------------------------------
module dsp_weight_store (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dsp_pkg::t_wr   i_wr,
    input  dsp_pkg::t_waddr i_rd_addr,
    output dsp_pkg::t_weight o_rd_data
);
    import dsp_pkg::*;

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

    t_weight          r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_weight          r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_vld  <= r_valid[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> src/dijkstra_shortest_paths_top.sv
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths_top
// Dense-matrix single-source shortest paths with per-vertex result words.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------
//   request  | i_req_type i_from_vertex i_to_vertex   | i_start & !o_busy
//            | i_edge_weight i_source_vertex          |
//   result   | o_vertex o_distance o_predecessor      | o_strobe, one cycle
//            | o_reachable o_last                     |
//   config   | i_cfg_data                             | i_cfg_we
//
// Loads may be issued back to back. The length of a run is set by the single
// read port of the distance memory, scanned one vertex per cycle for each
// selection pass and each relaxation pass. Rounds whose pick has no known
// distance skip the relaxation pass.
// Reset is synchronous; the weight matrix reads as empty after reset.
// The receiver cannot stall; result words come one per cycle.
// ----------------------------------------------------------------------------
module dijkstra_shortest_paths_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_req_type,
    input  logic [3:0]                   i_from_vertex,
    input  logic [3:0]                   i_to_vertex,
    input  logic [15:0]                  i_edge_weight,
    input  logic [3:0]                   i_source_vertex,
    input  logic                         i_cfg_we,
    input  logic [dsp_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                         o_strobe,
    output logic [3:0]                   o_vertex,
    output logic [19:0]                  o_distance,
    output logic [3:0]                   o_predecessor,
    output logic                         o_reachable,
    output logic                         o_last
);
    import dsp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_REL,
        S_OUT
    } t_state;

    typedef struct packed {
        t_dist dlen;
        t_vert pred;
    } t_dent;

    localparam logic [DIST_BITS:0] KEY_INF = '1;
    localparam t_dist DIST_SAT = '1;
    localparam logic [OUT_DIST_BITS-1:0] OUT_SAT = '1;

    t_state                r_state;
    logic [CFG_BITS-1:0]   r_vcount;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [CNT_BITS-1:0]   r_round;
    logic                  r_p_vld;
    t_vert                 r_p_idx;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_known;
    logic [DIST_BITS:0]    r_best_key;
    t_vert                 r_best_idx;
    t_vert                 r_src;
    t_dent                 r_dmem [MAX_VERTICES];
    t_dent                 r_drd;

    logic                  r_strobe;
    logic [3:0]            r_vertex;
    logic [19:0]           r_distance;
    logic [3:0]            r_pred;
    logic                  r_reach;
    logic                  r_last;

    logic [CNT_BITS-1:0]   n_act;
    logic                  n_issue;
    logic                  n_done;
    logic                  n_run;
    t_vert                 n_rd_idx;
    t_wr                   n_wr;
    t_weight               n_w;
    logic [DIST_BITS:0]    n_sum;
    t_dist                 n_cand;
    logic                  n_upd;
    logic [DIST_BITS:0]    n_key;
    logic                  n_take;
    logic                  n_last_round;
    t_dist                 n_out_dist;

    always_comb begin
        if (r_vcount == '0) begin
            n_act = CNT_BITS'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            n_act = CNT_BITS'(MAX_VERTICES);
        end else begin
            n_act = CNT_BITS'(r_vcount);
        end
    end

    assign n_rd_idx = r_cnt[VERT_BITS-1:0];
    assign n_issue  = (r_state != S_IDLE) && (r_cnt != n_act);
    assign n_done   = (r_cnt == n_act) && !r_p_vld;
    assign n_run    = (r_state == S_IDLE) && i_start && (i_req_type == REQ_RUN);

    assign n_wr.we   = (r_state == S_IDLE) && i_start && (i_req_type == REQ_LOAD)
                       && (32'(i_from_vertex) < MAX_VERTICES)
                       && (32'(i_to_vertex) < MAX_VERTICES);
    assign n_wr.addr = {i_from_vertex[VERT_BITS-1:0], i_to_vertex[VERT_BITS-1:0]};
    assign n_wr.data = i_edge_weight[WEIGHT_BITS-1:0];

    dsp_weight_store u_wstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (n_wr),
        .i_rd_addr ({r_best_idx, n_rd_idx}),
        .o_rd_data (n_w)
    );

    // relaxation of the vertex whose data just came back
    assign n_sum  = {1'b0, r_best_key[DIST_BITS-1:0]} + (DIST_BITS+1)'(n_w);
    assign n_cand = n_sum[DIST_BITS] ? DIST_SAT : n_sum[DIST_BITS-1:0];
    assign n_upd  = (r_state == S_REL) && r_p_vld && !r_visited[r_p_idx]
                    && (n_w != '0) && (!r_known[r_p_idx] || (n_cand < r_drd.dlen));

    // selection: unknown counts as infinity, ties to the higher index
    assign n_key  = r_known[r_p_idx] ? {1'b0, r_drd.dlen} : KEY_INF;
    assign n_take = (r_state == S_SEL) && r_p_vld && !r_visited[r_p_idx]
                    && (n_key <= r_best_key);

    assign n_last_round = (r_round + CNT_BITS'(1)) == (n_act - CNT_BITS'(1));

    assign n_out_dist = r_drd.dlen;

    always_ff @(posedge i_clk) begin
        if (n_upd) begin
            r_dmem[r_p_idx] <= '{dlen: n_cand, pred: r_best_idx};
        end else if (n_run) begin
            r_dmem[i_source_vertex[VERT_BITS-1:0]] <=
                '{dlen: '0, pred: i_source_vertex[VERT_BITS-1:0]};
        end
        r_drd <= r_dmem[n_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= CFG_BITS'(16);
            r_cnt      <= '0;
            r_round    <= '0;
            r_p_vld    <= 1'b0;
            r_visited  <= '0;
            r_known    <= '0;
            r_strobe   <= 1'b0;
            r_best_key <= KEY_INF;
            r_best_idx <= '0;
        end else begin
            r_strobe <= (r_state == S_OUT) && r_p_vld;
            r_p_vld  <= n_issue;
            r_p_idx  <= n_rd_idx;
            if (n_issue) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start && (i_req_type == REQ_RUN)) begin
                        r_src      <= i_source_vertex[VERT_BITS-1:0];
                        r_visited  <= '0;
                        r_known    <= (CNT_BITS'(i_source_vertex) < n_act)
                                      ? (MAX_VERTICES'(1) << i_source_vertex[VERT_BITS-1:0])
                                      : '0;
                        r_round    <= '0;
                        r_cnt      <= '0;
                        r_best_key <= KEY_INF;
                        r_state    <= (n_act == CNT_BITS'(1)) ? S_OUT : S_SEL;
                    end
                end
                S_SEL: begin
                    if (n_take) begin
                        r_best_key <= n_key;
                        r_best_idx <= r_p_idx;
                    end
                    if (n_done) begin
                        r_visited[r_best_idx] <= 1'b1;
                        r_cnt <= '0;
                        if (r_known[r_best_idx]) begin
                            r_state <= S_REL;
                        end else begin
                            r_round    <= r_round + CNT_BITS'(1);
                            r_best_key <= KEY_INF;
                            r_state    <= n_last_round ? S_OUT : S_SEL;
                        end
                    end
                end
                S_REL: begin
                    if (n_upd) begin
                        r_known[r_p_idx] <= 1'b1;
                    end
                    if (n_done) begin
                        r_cnt      <= '0;
                        r_round    <= r_round + CNT_BITS'(1);
                        r_best_key <= KEY_INF;
                        r_state    <= n_last_round ? S_OUT : S_SEL;
                    end
                end
                S_OUT: begin
                    if (r_p_vld) begin
                        r_vertex   <= 4'(r_p_idx);
                        r_reach    <= r_known[r_p_idx];
                        r_last     <= (CNT_BITS'(r_p_idx) + CNT_BITS'(1)) == n_act;
                        if (!r_known[r_p_idx]) begin
                            r_distance <= '0;
                            r_pred     <= 4'(r_src);
                        end else begin
                            r_distance <= (n_out_dist > DIST_BITS'(OUT_SAT))
                                          ? OUT_SAT : n_out_dist[OUT_DIST_BITS-1:0];
                            r_pred     <= 4'(r_drd.pred);
                        end
                    end
                    if (n_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_vertex      = r_vertex;
    assign o_distance    = r_distance;
    assign o_predecessor = r_pred;
    assign o_reachable   = r_reach;
    assign o_last        = r_last;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result word outside a run");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_req_type == REQ_RUN) |=> o_busy)
        else $error("run request not taken");

    a_rel_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL) |-> (r_known[r_best_idx] && r_visited[r_best_idx]))
        else $error("relaxing from a vertex without a distance");

    a_vertex_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe) |-> o_vertex == 4'($past(o_vertex) + 4'd1))
        else $error("result words out of order");

endmodule
